// ----- rtl/bfs_path_weight_sum_unit_macros.svh -----
// Assertion helpers for the path finder
`ifndef BFS_PATH_WEIGHT_SUM_UNIT_MACROS_SVH
`define BFS_PATH_WEIGHT_SUM_UNIT_MACROS_SVH

// implication checked every cycle outside reset
`define BFS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfs check failed");

// next-cycle implication, also active during reset
`define BFS_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("bfs check failed");

`endif

// ----- rtl/bfs_pkg.sv -----
`default_nettype none
package bfs_pkg;
    localparam int NODE_FW = 6;
    localparam int WIN_FW  = 10;
    localparam int SUM_FW  = 16;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 24;
    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;
    localparam int SUM_MAX = 32767;
    localparam int SUM_MIN = -32768;
    localparam int INTER_MAX = 63;

    typedef struct packed {
        logic clr;
        logic add;
    } t_acc_ctl;
endpackage
`default_nettype wire

// ----- rtl/bfs_path_weight_sum_unit.sv -----
// Shortest-hop path finder. Input tuser selects add-edge (0) or query (1).
// After reset the edge and node stores are cleared, with o_s_tready low.
// An add gives no result. A query clears the visited marks, then, for
// each node taken off the search queue, scans its adjacency row one
// edge-memory read per cycle, and at the end walks the path back hop by
// hop. One item is worked on at a time; a finished result waits in the
// output register.
`default_nettype none
module bfs_path_weight_sum_unit #(
    parameter int NODES       = 64,
    parameter int WEIGHT_BITS = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_s_tvalid,
    output logic                             o_s_tready,
    // node_a[5:0], node_b[11:6], weight_ab[21:12], weight_ba[31:22]
    input  wire logic [bfs_pkg::IN_W-1:0]    i_s_tdata,
    // op[0]
    input  wire logic [0:0]                  i_s_tuser,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    // found[0], intermediates[6:1], path_sum[22:7], sum_nonneg[23]
    output logic [bfs_pkg::OUT_W-1:0]        o_m_tdata
);
    localparam int NW = $clog2(NODES);
    localparam int EW = $clog2(NODES * NODES);
    localparam int CW = $clog2(NODES * NODES + 1);
    localparam int SW = WEIGHT_BITS + NW + 1;
    localparam logic [NW:0]   NODES_C  = (NW + 1)'(NODES);
    localparam logic [CW-1:0] CLR_LAST = CW'(NODES * NODES - 1);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_ADD_AB, S_ADD_WAB, S_ADD_BA, S_ADD_WBA,
        S_QA, S_QB, S_QC, S_VCLR, S_VINIT, S_DEQ, S_DEQW, S_SCAN,
        S_WALK_P, S_WALK_PW, S_WALK_W, S_DONE
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_clr;
    logic [NW-1:0] r_a, r_b, r_u, r_nd, r_cur, r_p, r_hops;
    logic signed [WEIGHT_BITS-1:0] r_wab, r_wba;
    logic [NW:0] r_n, r_head, r_tail;
    logic r_sv, r_pa, r_found, r_out_valid;
    logic [bfs_pkg::OUT_W-1:0] r_out_data;

    logic [WEIGHT_BITS:0] m_edge [NODES*NODES];
    logic                 m_node [NODES];
    logic                 m_vis  [NODES];
    logic [NW-1:0]        m_par  [NODES];
    logic [NW-1:0]        m_q    [NODES];
    logic [WEIGHT_BITS:0] r_e_rd;
    logic                 r_nd_rd, r_v_rd;
    logic [NW-1:0]        r_p_rd, r_q_rd;

    logic                 e_we, nd_we, nd_wd, v_we, v_wd, p_we, q_we, w_hit;
    logic [EW-1:0]        e_addr;
    logic [WEIGHT_BITS:0] e_wd;
    logic [NW-1:0]        nd_addr, v_wa, v_ra, p_wa, p_wd, p_ra, q_wa, q_wd, q_ra;
    bfs_pkg::t_acc_ctl    w_acc_ctl;
    logic signed [bfs_pkg::SUM_FW-1:0] w_sum;
    logic                 w_nonneg;
    logic [NW-1:0]        w_inter_raw;
    logic [bfs_pkg::NODE_FW-1:0] w_inter;
    logic [bfs_pkg::NODE_FW-1:0] w_in_a, w_in_b;
    logic                 w_in_rng;
    logic signed [bfs_pkg::WIN_FW-1:0] w_in_wab, w_in_wba;

    function automatic logic [EW-1:0] f_eaddr(input logic [NW-1:0] row,
                                              input logic [NW-1:0] col);
        logic [2*NW-1:0] full;
        full = {{NW{1'b0}}, row} * (2*NW)'(NODES) + {{NW{1'b0}}, col};
        return EW'(full);
    endfunction

    assign w_in_a   = i_s_tdata[5:0];
    assign w_in_b   = i_s_tdata[11:6];
    assign w_in_wab = i_s_tdata[21:12];
    assign w_in_wba = i_s_tdata[31:22];
    assign w_in_rng = (32'(w_in_a) < NODES) && (32'(w_in_b) < NODES);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign w_inter_raw = (r_hops > NW'(1)) ? r_hops - NW'(1) : '0;
    assign w_inter = (32'(w_inter_raw) > bfs_pkg::INTER_MAX) ?
                     bfs_pkg::NODE_FW'(bfs_pkg::INTER_MAX) :
                     bfs_pkg::NODE_FW'(w_inter_raw);

    bfs_acc #(.WEIGHT_BITS(WEIGHT_BITS), .SUM_BITS(SW)) u_acc (
        .i_clk    (i_clk),
        .i_ctl    (w_acc_ctl),
        .i_weight (r_e_rd[WEIGHT_BITS-1:0]),
        .o_sum    (w_sum),
        .o_nonneg (w_nonneg)
    );

    always_comb begin
        e_we = 1'b0; e_addr = '0; e_wd = '0;
        nd_we = 1'b0; nd_addr = '0; nd_wd = 1'b0;
        v_we = 1'b0; v_wa = '0; v_wd = 1'b0; v_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = '0;
        q_we = 1'b0; q_wa = '0; q_wd = '0; q_ra = '0;
        w_acc_ctl = '0;
        w_hit = r_sv && r_e_rd[WEIGHT_BITS] && !r_v_rd;
        unique case (r_state)
            S_CLR: begin
                e_we = 1'b1;
                e_addr = EW'(r_clr);
                if (32'(r_clr) < NODES) begin
                    nd_we = 1'b1;
                    nd_addr = NW'(r_clr);
                end
            end
            S_ADD_AB: begin
                e_addr = f_eaddr(r_a, r_b);
                nd_we = 1'b1; nd_addr = r_a; nd_wd = 1'b1;
            end
            S_ADD_WAB: begin
                e_addr = f_eaddr(r_a, r_b);
                e_we = !r_e_rd[WEIGHT_BITS];
                e_wd = {1'b1, r_wab};
                nd_we = 1'b1; nd_addr = r_b; nd_wd = 1'b1;
            end
            S_ADD_BA: begin
                e_addr = f_eaddr(r_b, r_a);
            end
            S_ADD_WBA: begin
                e_addr = f_eaddr(r_b, r_a);
                e_we = !r_e_rd[WEIGHT_BITS];
                e_wd = {1'b1, r_wba};
            end
            S_QA: nd_addr = r_a;
            S_QB: nd_addr = r_b;
            S_VCLR: begin
                v_we = 1'b1; v_wa = NW'(r_n);
            end
            S_VINIT: begin
                v_we = 1'b1; v_wa = r_a; v_wd = 1'b1;
                p_we = 1'b1; p_wa = r_a; p_wd = r_a;
                q_we = 1'b1; q_wa = '0; q_wd = r_a;
                w_acc_ctl.clr = 1'b1;
            end
            S_DEQ: q_ra = NW'(r_head);
            S_SCAN: begin
                e_addr = f_eaddr(r_u, NW'(r_n));
                v_ra = NW'(r_n);
                v_we = w_hit; v_wa = r_nd; v_wd = 1'b1;
                p_we = w_hit; p_wa = r_nd; p_wd = r_u;
                q_we = w_hit && (r_tail < NODES_C);
                q_wa = NW'(r_tail); q_wd = r_nd;
            end
            S_WALK_P: p_ra = r_cur;
            S_WALK_PW: e_addr = f_eaddr(r_p_rd, r_cur);
            S_WALK_W: w_acc_ctl.add = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            m_edge[e_addr] <= e_wd;
        end
        r_e_rd <= m_edge[e_addr];
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            m_node[nd_addr] <= nd_wd;
        end
        r_nd_rd <= m_node[nd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (v_we) begin
            m_vis[v_wa] <= v_wd;
        end
        r_v_rd <= m_vis[v_ra];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            m_par[p_wa] <= p_wd;
        end
        r_p_rd <= m_par[p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            m_q[q_wa] <= q_wd;
        end
        r_q_rd <= m_q[q_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the done state reloads the output register itself
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + CW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_a   <= NW'(w_in_a);
                        r_b   <= NW'(w_in_b);
                        r_wab <= WEIGHT_BITS'(w_in_wab);
                        r_wba <= WEIGHT_BITS'(w_in_wba);
                        r_found <= 1'b0;
                        if (i_s_tuser[0] == bfs_pkg::OP_ADD) begin
                            r_state <= w_in_rng ? S_ADD_AB : S_IDLE;
                        end else begin
                            r_state <= w_in_rng ? S_QA : S_DONE;
                        end
                    end
                end
                S_ADD_AB:  r_state <= S_ADD_WAB;
                S_ADD_WAB: r_state <= S_ADD_BA;
                S_ADD_BA:  r_state <= S_ADD_WBA;
                S_ADD_WBA: r_state <= S_IDLE;
                S_QA: r_state <= S_QB;
                S_QB: begin
                    r_pa    <= r_nd_rd;
                    r_state <= S_QC;
                end
                S_QC: begin
                    r_n <= '0;
                    r_state <= (r_pa && r_nd_rd) ? S_VCLR : S_DONE;
                end
                S_VCLR: begin
                    r_n <= r_n + (NW + 1)'(1);
                    if (r_n == NODES_C - (NW + 1)'(1)) begin
                        r_state <= S_VINIT;
                    end
                end
                S_VINIT: begin
                    r_head  <= '0;
                    r_tail  <= (NW + 1)'(1);
                    r_state <= S_DEQ;
                end
                S_DEQ: begin
                    if (r_head == r_tail) begin
                        r_state <= S_DONE;
                    end else begin
                        r_head  <= r_head + (NW + 1)'(1);
                        r_state <= S_DEQW;
                    end
                end
                S_DEQW: begin
                    r_u <= r_q_rd;
                    if (r_q_rd == r_b) begin
                        r_cur   <= r_b;
                        r_hops  <= '0;
                        r_state <= S_WALK_P;
                    end else begin
                        r_n     <= '0;
                        r_sv    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_sv <= (r_n < NODES_C);
                    if (r_n < NODES_C) begin
                        r_nd <= NW'(r_n);
                        r_n  <= r_n + (NW + 1)'(1);
                    end else begin
                        r_state <= S_DEQ;
                    end
                    if (w_hit && (r_tail < NODES_C)) begin
                        r_tail <= r_tail + (NW + 1)'(1);
                    end
                end
                S_WALK_P: begin
                    if (r_cur == r_a) begin
                        r_found <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WALK_PW;
                    end
                end
                S_WALK_PW: begin
                    r_p     <= r_p_rd;
                    r_state <= S_WALK_W;
                end
                S_WALK_W: begin
                    r_cur   <= r_p;
                    r_hops  <= r_hops + NW'(1);
                    r_state <= S_WALK_P;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_found ? {w_nonneg, w_sum, w_inter, 1'b1} : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/bfs_acc.sv -----
`default_nettype none
module bfs_acc #(
    parameter int WEIGHT_BITS = 10,
    parameter int SUM_BITS    = 17
) (
    input  wire logic                               i_clk,
    input  wire bfs_pkg::t_acc_ctl                  i_ctl,
    input  wire logic signed [WEIGHT_BITS-1:0]      i_weight,
    output logic signed [bfs_pkg::SUM_FW-1:0]       o_sum,
    output logic                                    o_nonneg
);
    logic signed [SUM_BITS-1:0] r_acc;
    logic signed [31:0]         w_wide;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.add) begin
            r_acc <= r_acc + SUM_BITS'(i_weight);
        end
    end

    // saturate to the 16-bit result
    always_comb begin
        w_wide = 32'(r_acc);
        if (w_wide > 32'(bfs_pkg::SUM_MAX)) begin
            o_sum = 16'(bfs_pkg::SUM_MAX);
        end else if (w_wide < 32'(bfs_pkg::SUM_MIN)) begin
            o_sum = 16'(bfs_pkg::SUM_MIN);
        end else begin
            o_sum = 16'(w_wide);
        end
        o_nonneg = !o_sum[bfs_pkg::SUM_FW-1];
    end
endmodule
`default_nettype wire

// ----- rtl/bfs_chk.sv -----
`default_nettype none
`include "bfs_path_weight_sum_unit_macros.svh"
module bfs_chk (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_s_tvalid,
    input wire logic                     o_s_tready,
    input wire logic [bfs_pkg::IN_W-1:0] i_s_tdata,
    input wire logic [0:0]               i_s_tuser,
    input wire logic                     o_m_tvalid,
    input wire logic                     i_m_tready,
    input wire logic [bfs_pkg::OUT_W-1:0] o_m_tdata
);
    // stores are swept after reset, so no transfer is taken right away
    `BFS_ASSERT_NEXT(a_clr_after_rst, i_clk, !i_rst_n, !o_s_tready)
    `BFS_ASSERT_IMPL(a_nonneg, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[0], o_m_tdata[23] == !o_m_tdata[22])
    `BFS_ASSERT_IMPL(a_miss_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tdata[0], o_m_tdata == '0)
    `BFS_ASSERT_NEXT(a_hold, i_clk, i_rst_n && o_m_tvalid && !i_m_tready, !i_rst_n || (o_m_tvalid && $stable(o_m_tdata)))
endmodule

bind bfs_path_weight_sum_unit bfs_chk u_bfs_chk (.*);
`default_nettype wire
